// ----- hw/rtl/paced_tap_to_hit_queue_top_macros.svh -----
// Assertion macros for the checker of the paced tap-to-hit queue.
// Depends on nothing; included by the checker module.
`ifndef PACED_TAP_TO_HIT_QUEUE_TOP_MACROS_SVH
`define PACED_TAP_TO_HIT_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptq assertion failed");

`endif

// ----- hw/rtl/ptq_pkg.sv -----
// Package for the paced tap-to-hit queue: widths, queue sizing, hit levels and
// the command and status structs between the controller and the group queues.
// Depends on nothing.
package ptq_pkg;

	localparam int NUM_GROUPS   = 2;
	localparam int NUM_CHANNELS = 8;
	localparam int CHANNEL_W    = 3;
	localparam int SUB_W        = 2;
	localparam int HOLD_W       = 16;
	localparam int LEVEL_W      = 15;

	localparam int QUEUE_DEPTH  = 16;
	localparam int QUEUE_IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEVEL_W-1:0] LEVEL_A        = 15'd16385;
	localparam logic [LEVEL_W-1:0] LEVEL_B        = 15'd16712;
	localparam logic [HOLD_W-1:0]  HOLD_OFF_RESET = 16'd4;

	// Command from the controller to one group queue.
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [SUB_W-1:0] sub;
	} fifo_cmd_t;

	// Status of one group queue.
	typedef struct packed {
		logic             empty;
		logic             full;
		logic [SUB_W-1:0] head_sub;
	} fifo_stat_t;

endpackage

// ----- hw/rtl/ptq_if.sv -----
// Valid/ready channel interfaces of the paced tap-to-hit queue: poll input,
// result output and the hold-off configuration write. Depends on ptq_pkg.
interface ptq_poll_if;
	import ptq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CHANNEL_W-1:0] channel;
	logic                 tapped;
	modport source (output valid, output channel, output tapped, input ready);
	modport sink (input valid, input channel, input tapped, output ready);
endinterface

interface ptq_result_if;
	import ptq_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic               dropped;
	modport source (output valid, output level, output dropped, input ready);
	modport sink (input valid, input level, input dropped, output ready);
endinterface

interface ptq_cfg_if;
	import ptq_pkg::*;
	logic              valid;
	logic              ready;
	logic [HOLD_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/paced_tap_to_hit_queue_top.sv -----
// Paced tap-to-hit queue.
// Channels: poll (sink) carries channel and tapped for one sensor poll; result
// (source) carries level and dropped, exactly one result transaction per poll;
// cfg (sink) writes the 16-bit hold-off reload value and is always ready.
// Timing: an accepted poll is captured in the input register, and its result moves
// into the output register once that register is free or being emptied by the receiver.
// Throughput: one poll per cycle while the receiver is not stalling; the whole decision is
// one pass of short logic between the input register and the output register, with queue
// state updated in the same cycle so the next poll sees it.
// Stall: while the output register holds an untaken result, the input register
// keeps its poll and poll ready falls only once both registers are full.
// Reset: arst_n clears the hold-off counters, level toggles, queue heads and fill
// counts, empties both pipeline registers and sets the hold-off reload to 4.
// Depends on ptq_pkg, ptq_if, ptq_fifo and ptq_ctrl.
module paced_tap_to_hit_queue_top (
	input  logic         clk,
	input  logic         arst_n,
	ptq_poll_if.sink     poll,
	ptq_result_if.source result,
	ptq_cfg_if.sink      cfg
);
	import ptq_pkg::*;

	logic                            poll_valid_s1;
	logic [CHANNEL_W-1:0]            channel_s1;
	logic                            tapped_s1;
	logic                            result_valid_s2;
	logic [LEVEL_W-1:0]              level_s2;
	logic                            dropped_s2;
	logic [HOLD_W-1:0]               hold_off_polls_q;
	logic                            go;
	logic [LEVEL_W-1:0]              level;
	logic                            dropped;
	fifo_cmd_t [NUM_GROUPS-1:0]      cmd;
	fifo_stat_t [NUM_GROUPS-1:0]     stat;

	// The input stage moves on when the output register is free or being emptied.
	assign go         = poll_valid_s1 && (!result_valid_s2 || result.ready);
	assign poll.ready = !poll_valid_s1 || go;
	assign cfg.ready  = 1'b1;

	// Hold-off reload register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_polls_q <= HOLD_OFF_RESET;
		end else if (cfg.valid) begin
			hold_off_polls_q <= cfg.data;
		end
	end

	// Valid bits of the input and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid_s1   <= 1'b0;
			result_valid_s2 <= 1'b0;
		end else begin
			if (poll.ready) begin
				poll_valid_s1 <= poll.valid;
			end
			if (go) begin
				result_valid_s2 <= 1'b1;
			end else if (result.ready) begin
				result_valid_s2 <= 1'b0;
			end
		end
	end

	// Payload of the input and output registers.
	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			channel_s1 <= poll.channel;
			tapped_s1  <= poll.tapped;
		end
		if (go) begin
			level_s2   <= level;
			dropped_s2 <= dropped;
		end
	end

	// One queue per group.
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_fifo
		ptq_fifo u_fifo (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.stat   (stat[g])
		);
	end

	ptq_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.channel        (channel_s1),
		.tapped         (tapped_s1),
		.hold_off_polls (hold_off_polls_q),
		.stat           (stat),
		.cmd            (cmd),
		.level          (level),
		.dropped        (dropped)
	);

	assign result.valid   = result_valid_s2;
	assign result.level   = level_s2;
	assign result.dropped = dropped_s2;

endmodule

// ----- hw/rtl/ptq_fifo.sv -----
// Circular queue of pending channels for one group, with head and fill count.
// Depends on ptq_pkg for sizing and the command and status structs.
module ptq_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  ptq_pkg::fifo_cmd_t cmd,
	output ptq_pkg::fifo_stat_t stat
);
	import ptq_pkg::*;

	localparam int SUM_W = QUEUE_CNT_W + 1;

	logic [SUB_W-1:0]       entry_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] head_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic [SUM_W-1:0]       tail_sum;
	logic [SUM_W-1:0]       tail_wrap;
	logic [QUEUE_IDX_W-1:0] tail_idx;
	logic [QUEUE_IDX_W-1:0] head_next;

	// Tail slot is head plus count, wrapped once since the sum stays below twice the depth.
	always_comb begin
		tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
		tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
		tail_idx  = tail_wrap[QUEUE_IDX_W-1:0];
		head_next = (head_q == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QUEUE_IDX_W'(1);
	end

	// Status toward the controller.
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign stat.head_sub = entry_q[head_q];

	// Head pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q  <= head_next;
				count_q <= count_q - QUEUE_CNT_W'(1);
			end else if (cmd.push) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end
		end
	end

	// Entry storage has no reset; only written entries are read.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			entry_q[tail_idx] <= cmd.sub;
		end
	end

endmodule

// ----- hw/rtl/ptq_ctrl.sv -----
// Per-poll decision logic: hold-off counters, per-channel level toggles and the
// push, pop and drop choices for the group queues. Depends on ptq_pkg.
module ptq_ctrl (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        go,
	input  logic [ptq_pkg::CHANNEL_W-1:0]               channel,
	input  logic                                        tapped,
	input  logic [ptq_pkg::HOLD_W-1:0]                  hold_off_polls,
	input  ptq_pkg::fifo_stat_t [ptq_pkg::NUM_GROUPS-1:0] stat,
	output ptq_pkg::fifo_cmd_t [ptq_pkg::NUM_GROUPS-1:0]  cmd,
	output logic [ptq_pkg::LEVEL_W-1:0]                 level,
	output logic                                        dropped
);
	import ptq_pkg::*;

	logic [NUM_GROUPS-1:0][HOLD_W-1:0] hold_q;
	logic [NUM_GROUPS-1:0][HOLD_W-1:0] hold_eff;
	logic [NUM_CHANNELS-1:0]           toggle_q;
	logic                              grp;
	logic [SUB_W-1:0]                  sub;
	logic                              hit;
	logic                              push;
	logic                              pop;

	assign grp = channel[CHANNEL_W-1];
	assign sub = channel[SUB_W-1:0];

	// A poll of channel zero counts both hold-offs down, stopping at zero.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			hold_eff[g] = (channel == '0 && hold_q[g] != '0) ? hold_q[g] - HOLD_W'(1) : hold_q[g];
		end
	end

	// Release the queue head, queue the tap, drop it when the queue is full, or hit at once.
	always_comb begin
		hit     = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		dropped = 1'b0;
		if (!stat[grp].empty) begin
			if (stat[grp].head_sub == sub && hold_eff[grp] == '0) begin
				pop = 1'b1;
				hit = 1'b1;
			end else if (tapped) begin
				if (stat[grp].full) begin
					dropped = 1'b1;
				end else begin
					push = 1'b1;
				end
			end
		end else if (tapped) begin
			if (hold_eff[grp] != '0) begin
				push = 1'b1;
			end else begin
				hit = 1'b1;
			end
		end
	end

	// Commands reach only the polled group's queue, and only on a transaction.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			cmd[g].push = go && push && (grp == 1'(g));
			cmd[g].pop  = go && pop && (grp == 1'(g));
			cmd[g].sub  = sub;
		end
	end

	assign level = hit ? (toggle_q[channel] ? LEVEL_B : LEVEL_A) : '0;

	// Hold-off reload on a hit and per-channel level toggle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			toggle_q <= '0;
		end else if (go) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				hold_q[g] <= (hit && grp == 1'(g)) ? hold_off_polls : hold_eff[g];
			end
			if (hit) begin
				toggle_q[channel] <= ~toggle_q[channel];
			end
		end
	end

endmodule

// ----- hw/rtl/ptq_checker.sv -----
// Port-level checker for the paced tap-to-hit queue and its bind to the top level.
// Depends on ptq_pkg and paced_tap_to_hit_queue_top_macros.svh.
`include "paced_tap_to_hit_queue_top_macros.svh"

module ptq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        poll_valid,
	input logic                        poll_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [ptq_pkg::LEVEL_W-1:0] level,
	input logic                        dropped
);
	import ptq_pkg::*;

	// A stalled result holds its payload.
	`PTQ_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(level) && $stable(dropped))

	// Only the two hit levels or zero ever leave the block.
	`PTQ_ASSERT_SAME(a_level_legal, clk, arst_n, result_valid, level == '0 || level == LEVEL_A || level == LEVEL_B)

	// A dropped tap never carries a hit.
	`PTQ_ASSERT_SAME(a_drop_no_hit, clk, arst_n, result_valid && dropped, level == '0)

	// After every poll transaction, a result is waiting once the poll has passed the input register.
	`PTQ_ASSERT_NEXT(a_poll_result, clk, arst_n, poll_valid && poll_ready, ##1 result_valid)

endmodule

bind paced_tap_to_hit_queue_top ptq_checker u_ptq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.poll_valid   (poll.valid),
	.poll_ready   (poll.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.level        (result.level),
	.dropped      (result.dropped)
);
